// ----- design/fifodel_pkg.sv -----
// fifodel_pkg: shared constants for the FIFO with delete-by-value block.
// Holds request codes, status codes and parameter defaults; no dependencies.
package fifodel_pkg;

  // Parameter defaults
  localparam int DEPTH_DEF    = 16;
  localparam int TAG_BITS_DEF = 32;

  // Fixed port widths
  localparam int ACTION_W = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;

  // Request codes
  localparam logic [ACTION_W-1:0] ACT_ENQ = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DEQ = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DEL = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

endpackage

// ----- design/fifo_with_delete_by_value.sv -----
// fifo_with_delete_by_value: ordered tag queue in a ring-buffer memory with
// enqueue, dequeue and delete-first-match. Depends on fifodel_pkg.
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------------------
//   input    | start / busy        | in_action, in_item_value
//   result   | out_valid (strobe)  | out_status, out_item_out, out_count
//
// Enqueue, rejected requests and unused codes: result in the cycle after accept.
// Dequeue: one read of the tag memory, then the result.
// Delete: one entry is read per cycle from the single read port, and entries
// behind the match are moved down by one through the write port.
// Reset (synchronous, rst_n low) empties the queue; memory contents are kept.
// Results are strobed for one cycle; the receiver cannot stall them.
module fifo_with_delete_by_value #(
  parameter int DEPTH    = fifodel_pkg::DEPTH_DEF,
  parameter int TAG_BITS = fifodel_pkg::TAG_BITS_DEF,
  localparam int CW      = $clog2(DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [fifodel_pkg::ACTION_W-1:0]  in_action,
  input  logic [fifodel_pkg::VALUE_W-1:0]   in_item_value,
  output logic                              out_valid,
  output logic [fifodel_pkg::STATUS_W-1:0]  out_status,
  output logic [fifodel_pkg::VALUE_W-1:0]   out_item_out,
  output logic [CW-1:0]                     out_count
);

  localparam int AW = $clog2(DEPTH);
  // stored tag width: tags come in on a 32-bit port
  localparam int TW = (TAG_BITS < fifodel_pkg::VALUE_W) ? TAG_BITS : fifodel_pkg::VALUE_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEQ  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  // physical slot of a logical position, counted from the head
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = (AW+1)'(base) + (AW+1)'(off);
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  logic [1:0]                         state_r, state_nxt;
  logic [AW-1:0]                      head_r, head_nxt;
  logic [CW-1:0]                      count_r, count_nxt;
  logic [AW-1:0]                      rdj_r, rdj_nxt;
  logic                               found_r, found_nxt;
  logic [TW-1:0]                      tag_r, tag_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [fifodel_pkg::STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [fifodel_pkg::VALUE_W-1:0]    out_item_r, out_item_nxt;

  logic [TW-1:0]  mem [DEPTH];
  logic [TW-1:0]  rd_data_r;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [TW-1:0]  mem_wdata;
  logic [AW-1:0]  mem_raddr;

  logic [TW-1:0]  tag_in;
  logic           hit;
  logic           last;

  assign tag_in = in_item_value[TW-1:0];
  assign hit    = (rd_data_r == tag_r);
  assign last   = ((CW'(rdj_r) + CW'(1)) == count_r);

  // tag memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // request sequencing and read-modify-write of the queue
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    rdj_nxt        = rdj_r;
    found_nxt      = found_r;
    tag_nxt        = tag_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_item_nxt   = out_item_r;
    mem_we         = 1'b0;
    mem_waddr      = phys(head_r, count_r[AW-1:0]);
    mem_wdata      = tag_in;
    mem_raddr      = head_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          out_item_nxt = '0;
          unique case (in_action)
            fifodel_pkg::ACT_ENQ: begin
              out_valid_nxt = 1'b1;
              if (tag_in == '0) begin
                out_status_nxt = fifodel_pkg::ST_NULL;
              end else if (count_r == CW'(DEPTH)) begin
                out_status_nxt = fifodel_pkg::ST_FULL;
              end else begin
                mem_we         = 1'b1;
                count_nxt      = count_r + CW'(1);
                out_status_nxt = fifodel_pkg::ST_OK;
              end
            end
            fifodel_pkg::ACT_DEQ: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = fifodel_pkg::ST_EMPTY;
              end else begin
                mem_raddr = head_r;
                state_nxt = S_DEQ;
              end
            end
            fifodel_pkg::ACT_DEL: begin
              if (tag_in == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = fifodel_pkg::ST_NULL;
              end else if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = fifodel_pkg::ST_EMPTY;
              end else begin
                tag_nxt   = tag_in;
                rdj_nxt   = '0;
                found_nxt = 1'b0;
                mem_raddr = head_r;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              // unused code: acknowledged, no change
              out_valid_nxt  = 1'b1;
              out_status_nxt = fifodel_pkg::ST_OK;
            end
          endcase
        end
      end

      S_DEQ: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = fifodel_pkg::ST_OK;
        out_item_nxt   = fifodel_pkg::VALUE_W'(rd_data_r);
        head_nxt       = phys(head_r, AW'(1));
        count_nxt      = count_r - CW'(1);
        state_nxt      = S_IDLE;
      end

      S_SCAN: begin
        // after the match, each entry moves down one slot
        if (found_r) begin
          mem_we    = 1'b1;
          mem_waddr = phys(head_r, rdj_r - AW'(1));
          mem_wdata = rd_data_r;
        end
        found_nxt = found_r | hit;
        mem_raddr = phys(head_r, rdj_r + AW'(1));
        rdj_nxt   = rdj_r + AW'(1);
        if (last) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '0;
          state_nxt     = S_IDLE;
          if (found_r | hit) begin
            out_status_nxt = fifodel_pkg::ST_OK;
            count_nxt      = count_r - CW'(1);
          end else begin
            out_status_nxt = fifodel_pkg::ST_NOT_FOUND;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      found_r     <= 1'b0;
      rdj_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      found_r     <= found_nxt;
      rdj_r       <= rdj_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    tag_r        <= tag_nxt;
    out_status_r <= out_status_nxt;
    out_item_r   <= out_item_nxt;
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_item_out = out_item_r;
  assign out_count    = count_r;

`ifndef ASSERT_OFF
  // queue never holds more than DEPTH tags
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("tag count exceeds depth");

  // a multi-cycle request always ends with its result strobe
  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |-> out_valid)
    else $error("busy dropped without a result");

  // full is only reported when the queue is full
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == fifodel_pkg::ST_FULL) |-> out_count == CW'(DEPTH))
    else $error("full status with room left");

  // a returned tag only comes with an ok status
  a_item_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item_out != '0) |-> out_status == fifodel_pkg::ST_OK)
    else $error("tag returned on a failed request");

  // a successful delete or dequeue shrinks the queue by one
  a_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && out_valid_nxt && out_status_nxt == fifodel_pkg::ST_OK)
      |=> out_count == $past(count_r) - CW'(1))
    else $error("removal did not shrink the queue");
`endif

endmodule
